// ----- hdl/mms_pkg.sv -----
// Shared constants, controller state type and command/status structs for the
// min/max contrast stretch block. No dependencies.
package mms_pkg;

    localparam int CHANNELS    = 4;
    localparam int CH_BITS     = $clog2(CHANNELS);
    localparam int SAMPLE_BITS = 16;
    localparam int BYTE_BITS   = 8;
    localparam int NUM_BITS    = SAMPLE_BITS + BYTE_BITS;
    localparam int DIV_STEPS   = BYTE_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    localparam logic [BYTE_BITS-1:0] BYTE_MAX = {BYTE_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]  CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic ready;
        logic capture;
        logic gather_update;
        logic prep;
        logic mul;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ----- hdl/mms_in_if.sv -----
// Input channel of the contrast stretch block: one sample word per handshake.
// Depends on mms_pkg.
interface mms_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [mms_pkg::CH_BITS-1:0]       channel;
    logic signed [mms_pkg::SAMPLE_BITS-1:0] sample;
    logic                              first_of_pass;

    modport source (output valid, action, channel, sample, first_of_pass, input ready);
    modport sink   (input valid, action, channel, sample, first_of_pass, output ready);
endinterface

// ----- hdl/mms_out_if.sv -----
// Output channel of the contrast stretch block: one mapped byte word per handshake.
// Depends on mms_pkg.
interface mms_out_if;
    logic                          valid;
    logic                          ready;
    logic [mms_pkg::BYTE_BITS-1:0] mapped_byte;
    logic                          constant_channel;
    logic [mms_pkg::CH_BITS-1:0]   out_channel;

    modport source (output valid, mapped_byte, constant_channel, out_channel, input ready);
    modport sink   (input valid, mapped_byte, constant_channel, out_channel, output ready);
endinterface

// ----- hdl/mms_ctrl.sv -----
// Sequencing state machine for the contrast stretch block.
// Depends on mms_pkg; drives the datapath through cmd_t and watches status_t.
module mms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_map,
    input  mms_pkg::status_t status,
    output mms_pkg::cmd_t    cmd
);
    import mms_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item_map ? S_PREP : S_GATHER;
                end
            end
            S_GATHER: state_next = S_IDLE;
            S_PREP:   state_next = S_MUL;
            S_MUL:    state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // The step counter is loaded as the numerator is formed and runs down
    // once per quotient bit.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == S_MUL)
        begin
            cnt_next = CNT_LAST;
        end
        else if (state_reg == S_DIV)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = item_valid;
            end
            S_GATHER: cmd.gather_update = 1'b1;
            S_PREP:   cmd.prep          = 1'b1;
            S_MUL:    cmd.mul           = 1'b1;
            S_DIV:    cmd.div_step      = 1'b1;
            S_DONE:   cmd.load_out      = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- hdl/mms_datapath.sv -----
// Datapath: per-channel min/max store, range set-up, scale by 255 and an
// 8-step restoring divider, plus the output register. Depends on mms_pkg.
module mms_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mms_pkg::cmd_t                      cmd,
    output mms_pkg::status_t                   status,
    input  logic [mms_pkg::CH_BITS-1:0]        channel,
    input  logic signed [mms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                               first_of_pass,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mms_pkg::BYTE_BITS-1:0]      mapped_byte,
    output logic                               constant_channel,
    output logic [mms_pkg::CH_BITS-1:0]        out_channel
);
    import mms_pkg::*;

    logic signed [SAMPLE_BITS-1:0] low_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] high_reg [CHANNELS];

    logic [CH_BITS-1:0]            ch_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          first_reg;

    logic [SAMPLE_BITS-1:0]        diff_reg;
    logic [SAMPLE_BITS-1:0]        den_reg;
    logic                          konst_reg;
    logic                          low_sat_reg;
    logic                          high_sat_reg;
    logic [SAMPLE_BITS-1:0]        rem_reg;
    logic [BYTE_BITS-1:0]          shift_reg;

    logic                          out_valid_reg;
    logic [BYTE_BITS-1:0]          byte_reg;
    logic                          konst_out_reg;
    logic [CH_BITS-1:0]            ch_out_reg;

    logic signed [SAMPLE_BITS-1:0] lo_sel;
    logic signed [SAMPLE_BITS-1:0] hi_sel;
    logic signed [SAMPLE_BITS:0]   diff_wide;
    logic signed [SAMPLE_BITS:0]   den_wide;
    logic [NUM_BITS-1:0]           num;
    logic [SAMPLE_BITS:0]          partial;
    logic                          fits;
    logic [SAMPLE_BITS-1:0]        rem_next;
    logic [BYTE_BITS-1:0]          byte_next;

    assign lo_sel    = low_reg[ch_reg];
    assign hi_sel    = high_reg[ch_reg];
    assign diff_wide = {sample_reg[SAMPLE_BITS-1], sample_reg} - {lo_sel[SAMPLE_BITS-1], lo_sel};
    assign den_wide  = {hi_sel[SAMPLE_BITS-1], hi_sel} - {lo_sel[SAMPLE_BITS-1], lo_sel};

    // Times 255 as a shift and one subtract; only used when low < sample < high,
    // where the difference fits the sample width unsigned.
    assign num = {diff_reg, {BYTE_BITS{1'b0}}} - {{BYTE_BITS{1'b0}}, diff_reg};

    // One restoring step: the remainder is always below the divisor.
    assign partial  = {rem_reg, shift_reg[BYTE_BITS-1]};
    assign fits     = partial >= {1'b0, den_reg};
    always_comb
    begin
        rem_next = partial[SAMPLE_BITS-1:0];
        if (fits)
        begin
            rem_next = SAMPLE_BITS'(partial - {1'b0, den_reg});
        end
    end

    always_comb
    begin
        if (konst_reg || low_sat_reg)
        begin
            byte_next = '0;
        end
        else if (high_sat_reg)
        begin
            byte_next = BYTE_MAX;
        end
        else
        begin
            byte_next = shift_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
        end
        else if (cmd.gather_update)
        begin
            if (first_reg)
            begin
                low_reg[ch_reg]  <= sample_reg;
                high_reg[ch_reg] <= sample_reg;
            end
            else
            begin
                if (sample_reg < lo_sel)
                begin
                    low_reg[ch_reg] <= sample_reg;
                end
                if (sample_reg > hi_sel)
                begin
                    high_reg[ch_reg] <= sample_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg     <= channel;
            sample_reg <= sample;
            first_reg  <= first_of_pass;
        end
        if (cmd.prep)
        begin
            diff_reg     <= diff_wide[SAMPLE_BITS-1:0];
            den_reg      <= den_wide[SAMPLE_BITS-1:0];
            konst_reg    <= !(hi_sel > lo_sel);
            low_sat_reg  <= sample_reg <= lo_sel;
            high_sat_reg <= sample_reg >= hi_sel;
        end
        if (cmd.mul)
        begin
            rem_reg   <= num[NUM_BITS-1:BYTE_BITS];
            shift_reg <= num[BYTE_BITS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[BYTE_BITS-2:0], fits};
        end
        if (cmd.load_out)
        begin
            byte_reg      <= byte_next;
            konst_out_reg <= konst_reg;
            ch_out_reg    <= ch_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mapped_byte      = byte_reg;
    assign constant_channel = konst_out_reg;
    assign out_channel      = ch_out_reg;

endmodule

// ----- hdl/min_max_stretch_to_u8.sv -----
// Channel  Role    Word
// -------  ------  ---------------------------------------------------
// item     sink    action, channel, sample, first_of_pass
// result   source  mapped_byte, constant_channel, out_channel
//
// A gather word is captured and then folded into its channel's bounds. A map word is
// captured, then passes range set-up, the scale by 255 and the bit-per-cycle restoring
// divider before its byte is loaded into the output register; then the next word can be taken.
// One word is worked on at a time; the next is taken while a result waits.
// A stalled result holds the map word in its last step until the output
// register frees. Reset clears the per-channel minimum and maximum to zero.
// Top level: joins mms_ctrl and mms_datapath; depends on mms_pkg, mms_in_if, mms_out_if.
module min_max_stretch_to_u8 (
    input  logic      clk,
    input  logic      rst_n,
    mms_in_if.sink    item,
    mms_out_if.source result
);
    import mms_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign item.ready = cmd.ready;

    mms_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_map   (item.action),
        .status     (status),
        .cmd        (cmd)
    );

    mms_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .channel          (item.channel),
        .sample           (item.sample),
        .first_of_pass    (item.first_of_pass),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .mapped_byte      (result.mapped_byte),
        .constant_channel (result.constant_channel),
        .out_channel      (result.out_channel)
    );

    // After a word is taken the block is not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("input taken again in the cycle after an accepted word");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("output register overwritten while still held");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> result.valid)
        else $error("loaded result not presented");

    a_constant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.constant_channel |-> result.mapped_byte == '0)
        else $error("constant channel with a non-zero byte");

endmodule

// ----- dv/mms_tb_pkg.sv -----
// Shared testbench types for the contrast stretch bench: word actions and the
// layout of one result word. Depends on mms_pkg.
package mms_tb_pkg;

    typedef enum logic {
        ACT_GATHER = 1'b0,
        ACT_MAP    = 1'b1
    } action_e;

    typedef struct packed {
        logic [mms_pkg::BYTE_BITS-1:0] mapped_byte;
        logic                          constant_channel;
        logic [mms_pkg::CH_BITS-1:0]   out_channel;
    } stretch_word_t;

endpackage

// ----- dv/mms_stretch_checker.sv -----
// Watches both channels of the contrast stretch block, keeps its own per-channel
// minimum and maximum, predicts each mapped byte and compares in order.
// Depends on mms_pkg, mms_tb_pkg, mms_in_if and mms_out_if.
module mms_stretch_checker (
    input  logic clk,
    input  logic rst_n,
    mms_in_if    item,
    mms_out_if   result,
    output int   mismatches,
    output int   outstanding
);
    import mms_pkg::*;
    import mms_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [SAMPLE_BITS-1:0] run_min [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] run_max [CHANNELS];
    stretch_word_t                 expected_bytes [$];

    function automatic stretch_word_t stretch_sample(input int ch,
                                                     input logic signed [SAMPLE_BITS-1:0] s);
        stretch_word_t w;
        longint        lo;
        longint        hi;
        longint        v;
        w.mapped_byte      = '0;
        w.constant_channel = 1'b1;
        w.out_channel      = CH_BITS'(ch);
        v = longint'(s);
        if (ch < CHANNELS)
        begin
            lo = longint'(run_min[ch]);
            hi = longint'(run_max[ch]);
            if (hi > lo)
            begin
                w.constant_channel = 1'b0;
                if (v <= lo)
                    w.mapped_byte = '0;
                else if (v >= hi)
                    w.mapped_byte = BYTE_MAX;
                else
                    w.mapped_byte = BYTE_BITS'(((v - lo) * 255) / (hi - lo));
            end
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stretch_word_t got;
        stretch_word_t want;
        int            ch;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                run_min[i] = '0;
                run_max[i] = '0;
            end
            expected_bytes.delete();
            mismatches = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.mapped_byte      = result.mapped_byte;
                got.constant_channel = result.constant_channel;
                got.out_channel      = result.out_channel;
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result word: byte %0d const %0d ch %0d",
                                 got.mapped_byte, got.constant_channel, got.out_channel);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch: expected byte %0d const %0d ch %0d,",
                                      " got byte %0d const %0d ch %0d"},
                                     want.mapped_byte, want.constant_channel,
                                     want.out_channel, got.mapped_byte,
                                     got.constant_channel, got.out_channel);
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                ch = int'(item.channel);
                if (item.action == ACT_MAP)
                    expected_bytes.push_back(stretch_sample(ch, item.sample));
                else if (ch < CHANNELS)
                begin
                    // A restart takes the sample as both bounds; otherwise it is folded in.
                    if (item.first_of_pass)
                    begin
                        run_min[ch] = item.sample;
                        run_max[ch] = item.sample;
                    end
                    else
                    begin
                        if (item.sample < run_min[ch])
                            run_min[ch] = item.sample;
                        if (item.sample > run_max[ch])
                            run_max[ch] = item.sample;
                    end
                end
            end
        end
        outstanding = expected_bytes.size();
    end

endmodule

// ----- dv/tb_min_max_stretch_to_u8.sv -----
// Top of the contrast stretch bench: clock, reset, stimulus and the verdict.
// Depends on mms_pkg, mms_tb_pkg, the channel interfaces and mms_stretch_checker.
module tb_min_max_stretch_to_u8;
    import mms_pkg::*;
    import mms_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 450;
    localparam int SETTLE_TICKS = 40;
    localparam int S_MIN        = -32768;
    localparam int S_MAX        = 32767;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   words_sent;
    int   cycle_count;
    int   mismatches;
    int   outstanding;

    mms_in_if  item();
    mms_out_if result();

    min_max_stretch_to_u8 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    mms_stretch_checker stretch_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        item.valid         = 1'b0;
        item.action        = ACT_GATHER;
        item.channel       = '0;
        item.sample        = '0;
        item.first_of_pass = 1'b0;
        result.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        words_sent         = 0;
        cycle_count        = 0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_min_max_stretch_to_u8: done, errors");
            $finish;
        end
    end

    function automatic int pick_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic send_word(input action_e act, input int ch, input int s, input logic first);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
        item.valid         <= 1'b1;
        item.action        <= act;
        item.channel       <= CH_BITS'(ch);
        item.sample        <= SAMPLE_BITS'(s);
        item.first_of_pass <= first;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Holds the input off until every predicted byte has come back.
    task automatic drain_results();
        @(negedge clk);
        item.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // One channel pass: a restarted gather run, then a burst of map words around
    // the gathered range, with the odd stray word thrown in.
    task automatic run_pass();
        int ch;
        int a;
        int b;
        int lo;
        int hi;
        int kind;
        int n_gather;
        int n_map;
        int s;
        ch   = $urandom_range(CHANNELS - 1);
        a    = int'($signed(SAMPLE_BITS'($urandom)));
        kind = $urandom_range(9);
        if (kind == 0)
            b = a;
        else if (kind <= 3)
            b = pick_between((a - 6 < S_MIN) ? S_MIN : a - 6, (a + 6 > S_MAX) ? S_MAX : a + 6);
        else if (kind == 4)
        begin
            a = S_MIN;
            b = S_MAX;
        end
        else
            b = int'($signed(SAMPLE_BITS'($urandom)));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;

        n_gather = $urandom_range(1, 5);
        send_word(ACT_GATHER, ch, a, 1'b1);
        if (n_gather > 1)
            send_word(ACT_GATHER, ch, b, 1'b0);
        for (int k = 2; k < n_gather; k++)
            send_word(ACT_GATHER, ch, pick_between(lo, hi), $urandom_range(19) == 0);

        if ($urandom_range(6) == 0)
            send_word(action_e'($urandom_range(1)), $urandom_range(CHANNELS - 1),
                      int'($signed(SAMPLE_BITS'($urandom))), 1'($urandom_range(1)));

        n_map = $urandom_range(1, 6);
        for (int k = 0; k < n_map; k++)
        begin
            kind = $urandom_range(9);
            if (kind < 7)
                s = pick_between((lo - 8 < S_MIN) ? S_MIN : lo - 8,
                                 (hi + 8 > S_MAX) ? S_MAX : hi + 8);
            else if (kind == 7)
                s = $urandom_range(1) ? hi : lo;
            else
                s = int'($signed(SAMPLE_BITS'($urandom)));
            send_word(ACT_MAP, ch, s, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int idle_by_phase  [4];
        int stall_by_phase [4];
        int phase_end;
        idle_by_phase  = '{0, 67, 0, 21};
        stall_by_phase = '{0, 0, 67, 21};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight after reset the bounds are both zero, so the channel is flat.
        send_word(ACT_MAP,    0, 123, 1'b0);
        // A fold without restart after reset still counts zero as a bound.
        send_word(ACT_GATHER, 1, 100, 1'b0);
        send_word(ACT_MAP,    1, 50, 1'b0);
        send_word(ACT_MAP,    1, -5, 1'b0);
        // Widest range the sample allows.
        send_word(ACT_GATHER, 2, S_MIN, 1'b1);
        send_word(ACT_GATHER, 2, S_MAX, 1'b0);
        send_word(ACT_MAP,    2, S_MIN, 1'b0);
        send_word(ACT_MAP,    2, S_MAX, 1'b0);
        send_word(ACT_MAP,    2, 0, 1'b0);
        send_word(ACT_MAP,    2, -1, 1'b0);
        // Below, above and inside a narrow range; the flag on a map word is ignored.
        send_word(ACT_GATHER, 3, 10, 1'b1);
        send_word(ACT_GATHER, 3, 20, 1'b0);
        send_word(ACT_MAP,    3, 5, 1'b0);
        send_word(ACT_MAP,    3, 25, 1'b0);
        send_word(ACT_MAP,    3, 19, 1'b0);
        send_word(ACT_MAP,    3, 12, 1'b1);
        // A restart on a single sample leaves the channel flat again.
        send_word(ACT_GATHER, 0, 7, 1'b1);
        send_word(ACT_MAP,    0, 7, 1'b0);
        send_word(ACT_MAP,    0, S_MIN, 1'b0);
        send_word(ACT_GATHER, 1, -1, 1'b1);
        send_word(ACT_GATHER, 1, 0, 1'b0);
        send_word(ACT_MAP,    1, -1, 1'b0);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
                run_pass();
            drain_results();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0)
            $display("tb_min_max_stretch_to_u8: done, clean");
        else
            $display("tb_min_max_stretch_to_u8: done, errors");
        $finish;
    end

endmodule
